/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/torq_pkg.sv */
// Package: shared types, codes and parameter defaults for the request queue.
package torq_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF      = 16;
    localparam int STAMP_BITS_DEF = 16;
    localparam int ID_BITS_DEF    = 8;

    // Opcodes carried on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } torq_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PLACE,
        ST_DONE
    } torq_state_t;

endpackage

/* rtl/timestamp_ordered_request_queue_core.sv */
// Top level: timestamp-ordered request queue held in one RAM, walked entry by entry.
//
//  channel   dir  tdata (low bit up)                                   tuser
//  s_axis    in   proc_id, stamp                                       opcode
//  m_axis    out  status, head_valid, head_proc_id, head_stamp,        -
//                 entry_count
//
// Sequence: an insert walks down from the tail, moving each entry that orders after
//   the new one up a slot, then writes the new one; full or empty skips the walk. A
//   delete walks every held entry from the head; empty skips it. One RAM read a cycle.
// Reset: the count clears at once; the RAM is not cleared, slots past the count
//   are never read. No clearing pass.
// Stalls: a new item is taken while the last result waits on m_axis; the block
//   stalls at the end of an item only while that result is still untaken.
module timestamp_ordered_request_queue_core #(
    parameter int  DEPTH      = torq_pkg::DEPTH_DEF,
    parameter int  STAMP_BITS = torq_pkg::STAMP_BITS_DEF,
    parameter int  ID_BITS    = torq_pkg::ID_BITS_DEF,
    localparam int WW         = ID_BITS + STAMP_BITS,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int IN_W       = ((WW + 7) / 8) * 8,
    localparam int OUT_W      = ((3 + WW + CW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // proc_id, stamp
    input  logic             s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status, head_valid, head_proc_id,
                                             // head_stamp, entry_count
);

    import torq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Entries are stored as {stamp, id}: an unsigned compare gives the queue order
    torq_state_t      state_reg, state_next;
    logic             op_reg, op_next;
    logic [WW-1:0]    key_reg, key_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [WW-1:0]    head_reg, head_next;
    torq_status_t     status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WW-1:0]    wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [WW-1:0]    rd_data;

    logic [WW-1:0]    in_key;
    logic             last_idx;
    logic             id_hit;
    logic             hit;
    logic             head_valid;

    torq_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_key     = s_axis_tdata[WW-1:0];
    assign last_idx   = (CW'(idx_reg) == count_reg - CW'(1));
    assign id_hit     = (rd_data[ID_BITS-1:0] == key_reg[ID_BITS-1:0]);
    assign hit        = found_reg || id_hit;
    assign head_valid = (count_reg != '0);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequencer: next state, RAM accesses and result bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        // Result taken downstream
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    key_next   = in_key;
                    found_next = 1'b0;
                    unique case (s_axis_tuser)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                // First entry goes straight into the head slot
                                wr_en       = 1'b1;
                                wr_addr     = '0;
                                wr_data     = in_key;
                                head_next   = in_key;
                                count_next  = CW'(1);
                                status_next = STATUS_OK;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                // Walk down from the tail
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg - CW'(1));
                                state_next = ST_WALK;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_NOT_FOUND;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                // Walk up from the head
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (rd_data > key_reg)
                    begin
                        // Entry orders after the new one: move it up a slot
                        wr_en   = 1'b1;
                        wr_addr = idx_reg + AW'(1);
                        wr_data = rd_data;
                        if (idx_reg == '0)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = idx_reg - AW'(1);
                            idx_next = idx_reg - AW'(1);
                        end
                    end
                    else
                    begin
                        // Slot above this entry is free for the new one
                        wr_en       = 1'b1;
                        wr_addr     = idx_reg + AW'(1);
                        wr_data     = key_reg;
                        count_next  = count_reg + CW'(1);
                        status_next = STATUS_OK;
                        state_next  = ST_DONE;
                    end
                end
                else
                begin
                    found_next = hit;
                    // Past the deleted entry every entry moves down a slot
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg - AW'(1);
                        wr_data = rd_data;
                        if (idx_reg == AW'(1))
                        begin
                            head_next = rd_data;
                        end
                    end
                    if (last_idx)
                    begin
                        status_next = hit ? STATUS_OK : STATUS_NOT_FOUND;
                        if (hit)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end

            ST_PLACE:
            begin
                // New entry becomes the head
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = key_reg;
                head_next   = key_reg;
                count_next  = count_reg + CW'(1);
                status_next = STATUS_OK;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({count_reg,
                                             head_valid ? head_reg : {WW{1'b0}},
                                             head_valid,
                                             status_reg});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            op_reg        <= OP_INSERT;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            op_reg        <= op_next;
            status_reg    <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        head_reg     <= head_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* rtl/torq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module torq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port (old data on a collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/torq_checker.sv */
// Checker on the request queue's ports, bound to the top level.
`include "assert_macros.svh"

module torq_checker #(
    parameter int  DEPTH      = torq_pkg::DEPTH_DEF,
    parameter int  STAMP_BITS = torq_pkg::STAMP_BITS_DEF,
    parameter int  ID_BITS    = torq_pkg::ID_BITS_DEF,
    localparam int WW         = ID_BITS + STAMP_BITS,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int OUT_W      = ((3 + WW + CW + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata    // status, head_valid, head_proc_id,
                                            // head_stamp, entry_count
);

    import torq_pkg::*;

    localparam int CNT_L = 3 + WW;

    logic [1:0]    out_status;
    logic          out_hv;
    logic [WW-1:0] out_head;
    logic [CW-1:0] out_count;
    logic          out_stall;
    logic          head_count_ok;
    logic          count_ok;
    logic          status_ok;
    logic          empty_head_ok;

    assign out_status = m_axis_tdata[1:0];
    assign out_hv     = m_axis_tdata[2];
    assign out_head   = m_axis_tdata[3 +: WW];
    assign out_count  = m_axis_tdata[CNT_L +: CW];

    // Per-item field checks, true whenever no result is offered
    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign head_count_ok = !m_axis_tvalid || (out_hv == (out_count != '0));
    assign count_ok      = !m_axis_tvalid || (out_count <= CW'(DEPTH));
    assign status_ok     = !m_axis_tvalid || (out_status == STATUS_OK) ||
                           (out_status == STATUS_NOT_FOUND) || (out_status == STATUS_FULL);
    assign empty_head_ok = !m_axis_tvalid || out_hv || (out_head == '0);

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // Head valid agrees with the count
    `ASSERT_ALWAYS(a_head_count, head_count_ok, "head_valid and entry_count disagree")

    // Count never exceeds the capacity
    `ASSERT_ALWAYS(a_count_range, count_ok, "entry_count above capacity")

    // Only defined status codes, and an empty queue shows a zero head
    `ASSERT_ALWAYS(a_status_code, status_ok, "undefined status code")
    `ASSERT_ALWAYS(a_empty_head, empty_head_ok, "empty queue shows a non-zero head")

endmodule

bind timestamp_ordered_request_queue_core torq_checker #(
    .DEPTH      (DEPTH),
    .STAMP_BITS (STAMP_BITS),
    .ID_BITS    (ID_BITS)
) u_torq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
